[rtl/ctp_pkg.sv]
// Shared types and constants of the chunky-to-planar packer.
package ctp_pkg;

  // Hardware plane lanes carried between the front and back parts.
  localparam int HW_PLANES   = 8;
  localparam int ADDR_W      = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_DATA_W  = 13;

  // Input action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PLANE_COUNT = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  // One input request.
  typedef struct packed {
    logic       action;
    logic [7:0] pixel_code;
    logic [7:0] palette_slot;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [2:0]        plane_index;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        plane_byte;
    logic              bad_pixel;
    logic              last;
  } out_item_t;

  // One emission job: a byte for every plane, plus an optional padding group.
  typedef struct packed {
    logic [HW_PLANES-1:0][7:0] bytes;
    logic                      bad;
    logic [3:0]                planes;
    logic [ADDR_W-1:0]         addr;
    logic                      pad;
    logic [ADDR_W-1:0]         pad_addr;
  } job_t;

endpackage

[rtl/ctp_front.sv]
// Front part: configuration, code table lookup, plane shifting and job creation.
module ctp_front
  import ctp_pkg::*;
#(
  parameter int MAX_PLANES  = 8,
  parameter int MAX_WIDTH   = 4096,
  parameter int PLANE_BYTES = 16777216
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [ADDR_W:0] PB = (ADDR_W + 1)'(PLANE_BYTES);

  logic [3:0]            plane_count_r;
  logic [CFG_DATA_W-1:0] image_width_r;

  logic [7:0]   slot_mem [256];
  logic [255:0] entry_valid_r;
  logic [7:0]   slot_rd_r;
  logic         hit_r;
  logic         s1_valid_r, s1_valid_nxt;

  logic [7:0]        shift_r   [MAX_PLANES];
  logic [7:0]        shift_upd [MAX_PLANES];
  logic [7:0]        shift_nxt [MAX_PLANES];
  logic [CW-1:0]     col_r, col_nxt, col_inc, eff_w;
  logic [ADDR_W-1:0] off_r, off_nxt, off1, off2;
  logic              bad_r, bad_nxt, bad_upd;

  logic              in_accept, s1_go, row_end, emit, pad;
  logic [7:0]        slot;
  logic [2:0]        fill, sh;
  logic [3:0]        eff_n;
  logic [16:0]       w_ext;
  logic [ADDR_W:0]   off_p1, off_p2;
  logic [HW_PLANES-1:0][7:0] job_bytes;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= 4'd1;
      image_width_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PLANE_COUNT: plane_count_r <= cfg_wdata[3:0];
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pixel stage holds until the job queue has room.
  assign in_stall  = s1_valid_r && q_full;
  assign in_accept = in_valid && !in_stall;
  assign s1_go     = s1_valid_r && !q_full;

  // Code table: a load writes the entry, a pixel reads it.
  always_ff @(posedge clk) begin
    if (in_accept && in_data.action == ACT_LOAD) begin
      slot_mem[in_data.pixel_code] <= in_data.palette_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      slot_rd_r <= slot_mem[in_data.pixel_code];
      hit_r     <= entry_valid_r[in_data.pixel_code];
    end
  end

  // Entry valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (in_accept && in_data.action == ACT_LOAD) begin
      entry_valid_r[in_data.pixel_code] <= 1'b1;
    end
  end

  // Effective register values after clamping.
  always_comb begin
    w_ext = {4'd0, image_width_r};
    if (w_ext == 17'd0) begin
      eff_w = CW'(1);
    end else if (w_ext > 17'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(w_ext);
    end
    if (plane_count_r == 4'd0) begin
      eff_n = 4'd1;
    end else if (plane_count_r > 4'(MAX_PLANES)) begin
      eff_n = 4'(MAX_PLANES);
    end else begin
      eff_n = plane_count_r;
    end
  end

  // Pixel stage: shift in the slot bits and decide whether a byte completes.
  always_comb begin
    slot = hit_r ? slot_rd_r : 8'd0;
    for (int p = 0; p < MAX_PLANES; p++) begin
      shift_upd[p] = {shift_r[p][6:0], slot[p]};
    end
    bad_upd = bad_r | !hit_r;
    col_inc = col_r + CW'(1);
    row_end = col_inc >= eff_w;
    fill    = col_inc[2:0];
    emit    = (fill == 3'd0) || row_end;
    // An even byte index at row end means an odd byte count: pad one more.
    pad     = row_end && !col_r[3];
    // Left-align a partial byte; a full byte shifts by zero.
    sh      = 3'(4'd8 - {1'b0, fill});
  end

  // Byte address advance with wrap at the plane size.
  always_comb begin
    off_p1 = {1'b0, off_r} + (ADDR_W + 1)'(1);
    off1   = (off_p1 >= PB) ? '0 : off_p1[ADDR_W-1:0];
    off_p2 = {1'b0, off1} + (ADDR_W + 1)'(1);
    off2   = (off_p2 >= PB) ? '0 : off_p2[ADDR_W-1:0];
  end

  // Plane bytes of the job; unused hardware lanes stay zero.
  for (genvar g = 0; g < HW_PLANES; g++) begin : g_bytes
    if (g < MAX_PLANES) begin : g_used
      assign job_bytes[g] = shift_upd[g] << sh;
    end else begin : g_unused
      assign job_bytes[g] = 8'd0;
    end
  end

  always_comb begin
    q_job.bytes    = job_bytes;
    q_job.bad      = bad_upd;
    q_job.planes   = eff_n;
    q_job.addr     = off_r;
    q_job.pad      = pad;
    q_job.pad_addr = off1;
    q_push         = s1_go && emit;
  end

  // Next state of the pixel stage.
  always_comb begin
    s1_valid_nxt = (in_accept && in_data.action == ACT_PIXEL) || (s1_valid_r && q_full);
    col_nxt      = col_r;
    off_nxt      = off_r;
    bad_nxt      = bad_r;
    for (int p = 0; p < MAX_PLANES; p++) begin
      shift_nxt[p] = shift_r[p];
    end
    if (s1_go) begin
      col_nxt = row_end ? '0 : col_inc;
      bad_nxt = emit ? 1'b0 : bad_upd;
      if (emit) begin
        off_nxt = pad ? off2 : off1;
      end
      for (int p = 0; p < MAX_PLANES; p++) begin
        shift_nxt[p] = emit ? 8'd0 : shift_upd[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      off_r      <= '0;
      bad_r      <= 1'b0;
      for (int p = 0; p < MAX_PLANES; p++) begin
        shift_r[p] <= 8'd0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_r      <= col_nxt;
      off_r      <= off_nxt;
      bad_r      <= bad_nxt;
      for (int p = 0; p < MAX_PLANES; p++) begin
        shift_r[p] <= shift_nxt[p];
      end
    end
  end

endmodule

[rtl/ctp_queue.sv]
// Short job queue between the front and back parts.
module ctp_queue
  import ctp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output job_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = count_r == (PW + 1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/ctp_back.sv]
// Back part: expands each job into one result per plane, then padding results.
module ctp_back
  import ctp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  job_t      job_r;
  logic      job_v_r, job_v_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic      pad_r, pad_nxt;
  logic      out_v_r, out_v_nxt;
  out_item_t out_r;

  logic      fire, plane_end, job_end;
  logic [3:0] n_m1;

  // One result leaves the job each cycle the output register can take it.
  always_comb begin
    fire      = job_v_r && (!out_v_r || !out_stall);
    n_m1      = job_r.planes - 4'd1;
    plane_end = {1'b0, cnt_r} == n_m1;
    job_end   = plane_end && (pad_r || !job_r.pad);
    q_pop     = q_valid && (!job_v_r || (fire && job_end));
  end

  // Job walk: plane group, then padding group when requested.
  always_comb begin
    job_v_nxt = job_v_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    out_v_nxt = out_v_r && out_stall;
    if (fire) begin
      out_v_nxt = 1'b1;
      if (plane_end) begin
        cnt_nxt = 3'd0;
        if (job_end) begin
          job_v_nxt = 1'b0;
        end else begin
          pad_nxt = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
    if (q_pop) begin
      job_v_nxt = 1'b1;
      cnt_nxt   = 3'd0;
      pad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      cnt_r   <= 3'd0;
      pad_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      cnt_r   <= cnt_nxt;
      pad_r   <= pad_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Job and result payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (fire) begin
      out_r.plane_index  <= cnt_r;
      out_r.byte_address <= pad_r ? job_r.pad_addr : job_r.addr;
      out_r.plane_byte   <= pad_r ? 8'd0 : job_r.bytes[cnt_r];
      out_r.bad_pixel    <= pad_r ? 1'b0 : job_r.bad;
      out_r.last         <= job_end;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[rtl/chunky_to_planar_packer.sv]
// Chunky-to-planar packer top level: front, job queue and back.
//
// Input channel (in_valid, in_stall, in_data): each request either loads one
// code-to-slot table entry or delivers one pixel code. A new request can be
// taken every cycle; in_stall rises only when the pixel stage holds a pixel
// and the four-entry job queue is full.
// Result channel (out_valid, out_stall, out_data): one plane byte per request,
// planes in ascending order, padding bytes after them at a row end with an odd
// byte count; last marks the final byte caused by one pixel.
// Path: pixel stage, job queue, job register, result register. Throughput, while
// neither side stalls: one pixel per cycle in, one result per cycle out. A
// completed byte group of N planes gives N results (2N with padding), so the
// sustained pixel rate is set by the single result register. The user writes
// configuration (cfg_we, cfg_addr, cfg_wdata) only while idle; the block does
// not enforce this. Reset clears the table valid bits, the shift registers, the
// column and address counters and the queue, and sets both registers to one. A
// stalled result holds its payload; the queue fills and then the input stalls.
module chunky_to_planar_packer
  import ctp_pkg::*;
#(
  parameter int MAX_PLANES  = 8,
  parameter int MAX_WIDTH   = 4096,
  parameter int PLANE_BYTES = 16777216
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic q_push, q_full, q_not_empty, q_pop;
  job_t q_job, q_head;

  // Classification, table lookup and byte assembly.
  ctp_front #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_WIDTH  (MAX_WIDTH),
    .PLANE_BYTES(PLANE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Decoupling queue.
  ctp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Result sequencing.
  ctp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_not_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[rtl/ctp_checker.sv]
// Port-level checker for the chunky-to-planar packer and its bind statement.
module ctp_checker
  import ctp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result request stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the pixel stage, so the input is ready right after it.
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind chunky_to_planar_packer ctp_checker u_ctp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
